/* rtl/rssc_pkg.sv */
`default_nettype none
package rssc_pkg;

    localparam int DATA_W       = 32;
    localparam int BETA_W       = 18;
    localparam int BETA_FRAC    = 16;
    localparam int PHASE_W      = 16;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int ANG_W        = 32;
    localparam int CORDIC_W     = 36;
    localparam int ATAN_LEN     = 24;
    localparam int DEF_DATA_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STAGES  = 16;

    localparam logic [ANG_W-1:0] PI_Q28 = 32'd843314857;

    localparam logic [MODE_W-1:0] MODE_ER    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HIO   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HPR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RAAR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PHIO  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd3;

    localparam logic [BETA_W-1:0]  BETA_RST  = 18'd58982;
    localparam logic signed [PHASE_W-1:0] UPPER_RST = 16'sd25736;
    localparam logic signed [PHASE_W-1:0] LOWER_RST = -16'sd25736;

    typedef struct packed {
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic signed [DATA_W-1:0] pr;
        logic signed [DATA_W-1:0] pi;
        logic                     outside;
        logic                     last;
    } voxel_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANG_W-1:0]    z;
        logic                       zero;
    } vec_t;

    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 32'sd210828714;
                5'd1:  r = 32'sd124459457;
                5'd2:  r = 32'sd65760959;
                5'd3:  r = 32'sd33381290;
                5'd4:  r = 32'sd16755422;
                5'd5:  r = 32'sd8385879;
                5'd6:  r = 32'sd4193963;
                5'd7:  r = 32'sd2097109;
                5'd8:  r = 32'sd1048571;
                5'd9:  r = 32'sd524287;
                default: r = 32'sd1 <<< (5'd28 - i);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/rssc_cell.sv */
`default_nettype none
module rssc_cell
    import rssc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   vld_in,
    input  wire voxel_t vox_in,
    input  wire vec_t   vec_in,
    output logic        vld_out,
    output voxel_t      vox_out,
    output vec_t        vec_out
);

    logic   vld_reg;
    voxel_t vox_reg;
    vec_t   vec_reg, vec_next;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] a;

    always_comb
    begin
        xs = vec_in.x >>> STAGE;
        ys = vec_in.y >>> STAGE;
        a  = atan_q28(5'(STAGE));
        vec_next = vec_in;
        if (!vec_in.y[CORDIC_W-1])
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + a;
        end
        else
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        vox_reg <= vox_in;
        vec_reg <= vec_next;
    end

    assign vld_out = vld_reg;
    assign vox_out = vox_reg;
    assign vec_out = vec_reg;

endmodule
`default_nettype wire

/* rtl/rssc_update.sv */
`default_nettype none
module rssc_update
    import rssc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       vld_in,
    input  wire voxel_t                     vox_in,
    input  wire logic signed [ANG_W-1:0]    z_in,
    input  wire logic                       zero_in,
    input  wire logic [MODE_W-1:0]          mode,
    input  wire logic [BETA_W-1:0]          beta,
    input  wire logic signed [PHASE_W-1:0]  upper,
    input  wire logic signed [PHASE_W-1:0]  lower,
    output logic                            vld_out,
    output logic signed [DATA_W-1:0]        nr_out,
    output logic signed [DATA_W-1:0]        ni_out,
    output logic                            sel_out,
    output logic                            last_out
);

    localparam int P_W = 56;

    // stage 1: products and select
    logic                   v1_reg;
    logic signed [P_W-1:0]  hr_reg, hi_reg, lr_reg, li_reg, qr_reg, qi_reg;
    logic                   sel1_reg, er1_reg, raar1_reg, last1_reg;
    logic signed [DATA_W-1:0] cr1_reg, ci1_reg;
    logic signed [DATA_W-1:0] pr1_reg, pi1_reg;

    logic signed [BETA_W:0]   bs;
    logic signed [BETA_W+1:0] omb, om2b;
    logic signed [DATA_W+1:0] br, bi;
    logic signed [ANG_W-1:0]  zr;
    logic signed [PHASE_W:0]  ph;
    logic                     sel_next;
    logic signed [P_W-1:0]    lhs_r, lhs_i, rhs_r, rhs_i;

    always_comb
    begin
        bs   = {1'b0, beta};
        omb  = (20'sd1 <<< BETA_FRAC) - 20'(bs);
        om2b = (20'sd1 <<< BETA_FRAC) - (20'(bs) <<< 1);
        br   = 34'(vox_in.cr) * 34'sd2 - 34'(vox_in.pr);
        bi   = 34'(vox_in.ci) * 34'sd2 - 34'(vox_in.pi);
        zr   = (z_in + 32'sd16384) >>> 15;
        ph   = zero_in ? '0 : 17'(zr);
        lhs_r = P_W'(br) <<< BETA_FRAC;
        lhs_i = P_W'(bi) <<< BETA_FRAC;
        rhs_r = P_W'(omb) * P_W'(vox_in.cr);
        rhs_i = P_W'(omb) * P_W'(vox_in.ci);
        case (mode)
            MODE_ER:   sel_next = vox_in.outside;
            MODE_HIO:  sel_next = vox_in.outside;
            MODE_HIOP: sel_next = vox_in.outside ||
                                  (vox_in.cr[DATA_W-1] && vox_in.ci[DATA_W-1]);
            MODE_HPR:  sel_next = vox_in.outside || ((lhs_r < rhs_r) && (lhs_i < rhs_i));
            MODE_RAAR: sel_next = vox_in.outside || (br[DATA_W+1] && bi[DATA_W+1]);
            MODE_PHIO: sel_next = vox_in.outside || (ph > 17'(upper)) || (ph < 17'(lower));
            default:   sel_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            vld_out <= 1'b0;
        end
        else
        begin
            v1_reg  <= vld_in;
            vld_out <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hr_reg    <= P_W'(bs) * P_W'(vox_in.cr);
        hi_reg    <= P_W'(bs) * P_W'(vox_in.ci);
        lr_reg    <= P_W'(bs) * P_W'(vox_in.pr);
        li_reg    <= P_W'(bs) * P_W'(vox_in.pi);
        qr_reg    <= P_W'(om2b) * P_W'(vox_in.cr);
        qi_reg    <= P_W'(om2b) * P_W'(vox_in.ci);
        sel1_reg  <= sel_next;
        er1_reg   <= (mode == MODE_ER);
        raar1_reg <= (mode == MODE_RAAR);
        last1_reg <= vox_in.last;
        cr1_reg   <= vox_in.cr;
        ci1_reg   <= vox_in.ci;
        pr1_reg   <= vox_in.pr;
        pi1_reg   <= vox_in.pi;
    end

    // stage 2: round, combine, saturate, and pick pass-through, zero or update
    logic signed [P_W-1:0] half, rr, ri, tr, ti;

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] mx, mn;
        begin
            mx = P_W'(32'sh7fffffff);
            mn = -mx - P_W'(1);
            if (v > mx)
                return mx[DATA_W-1:0];
            else if (v < mn)
                return mn[DATA_W-1:0];
            else
                return v[DATA_W-1:0];
        end
    endfunction

    always_comb
    begin
        half = P_W'(1) <<< (BETA_FRAC - 1);
        if (raar1_reg)
        begin
            tr = (lr_reg - qr_reg + half) >>> BETA_FRAC;
            ti = (li_reg - qi_reg + half) >>> BETA_FRAC;
            rr = tr;
            ri = ti;
        end
        else
        begin
            tr = (hr_reg + half) >>> BETA_FRAC;
            ti = (hi_reg + half) >>> BETA_FRAC;
            rr = P_W'(pr1_reg) - tr;
            ri = P_W'(pi1_reg) - ti;
        end
    end

    always_ff @(posedge clk)
    begin
        last_out <= last1_reg;
        sel_out  <= sel1_reg;
        if (!sel1_reg)
        begin
            nr_out <= cr1_reg;
            ni_out <= ci1_reg;
        end
        else if (er1_reg)
        begin
            nr_out <= '0;
            ni_out <= '0;
        end
        else
        begin
            nr_out <= sat(rr);
            ni_out <= sat(ri);
        end
    end

endmodule
`default_nettype wire

/* rtl/real_space_support_constraint_unit.sv */
// real-space support constraint for iterative phase retrieval
// channels: start/busy command input carrying one complex voxel (current and
// previous iterate, Q16.16), a support bit and an end-of-volume mark; results
// appear on new_real/new_imag/was_replaced/last_out for one cycle with done
// configuration: cfg_valid/cfg_ready write port, cfg_index selects mode, beta,
// upper and lower phase limit; cfg_ready is always high
// throughput: one voxel per clock, busy is never asserted
// pipeline: results are registered in the prep stage, then in the row of
// vectoring cells (one cell per atan stage) and in two update stages
// the update stage forms beta products in its first stage and rounds/saturates
// in its second
// reset: rst_n clears all valid flags and loads register defaults
// (ER mode, beta 0.9, phase limits +/- pi)
// the receiver cannot stall: every result is shown exactly once
`default_nettype none
module real_space_support_constraint_unit
    import rssc_pkg::*;
#(
    parameter int DATA_FRAC_BITS = DEF_DATA_FRAC_BITS,
    parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] cur_real,
    input  wire logic signed [DATA_W-1:0] cur_imag,
    input  wire logic signed [DATA_W-1:0] prev_real,
    input  wire logic signed [DATA_W-1:0] prev_imag,
    input  wire logic                     in_support,
    input  wire logic                     last_voxel,
    output logic                          done,
    output logic signed [DATA_W-1:0]      new_real,
    output logic signed [DATA_W-1:0]      new_imag,
    output logic                          was_replaced,
    output logic                          last_out,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int FRAC_UNUSED = DATA_FRAC_BITS - DATA_FRAC_BITS;

    logic [MODE_W-1:0]         mode_reg;
    logic [BETA_W-1:0]         beta_reg;
    logic signed [PHASE_W-1:0] upper_reg, lower_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ER;
            beta_reg  <= BETA_RST;
            upper_reg <= UPPER_RST;
            lower_reg <= LOWER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                REG_BETA:  beta_reg  <= cfg_data[BETA_W-1:0];
                REG_UPPER: upper_reg <= cfg_data[PHASE_W-1:0];
                REG_LOWER: lower_reg <= cfg_data[PHASE_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // prep stage: fold left half plane
    logic   v0_reg;
    voxel_t vox0_reg;
    vec_t   vec0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        vox0_reg.cr      <= cur_real;
        vox0_reg.ci      <= cur_imag;
        vox0_reg.pr      <= prev_real;
        vox0_reg.pi      <= prev_imag;
        vox0_reg.outside <= ~in_support;
        vox0_reg.last    <= last_voxel;
        vec0_reg.zero    <= (cur_real == 0) && (cur_imag == 0);
        if (cur_real[DATA_W-1])
        begin
            vec0_reg.x <= -CORDIC_W'(cur_real) + CORDIC_W'(FRAC_UNUSED);
            vec0_reg.y <= -CORDIC_W'(cur_imag);
            vec0_reg.z <= cur_imag[DATA_W-1] ? -PI_Q28 : PI_Q28;
        end
        else
        begin
            vec0_reg.x <= CORDIC_W'(cur_real);
            vec0_reg.y <= CORDIC_W'(cur_imag);
            vec0_reg.z <= '0;
        end
    end

    logic   vld_c [NST+1];
    voxel_t vox_c [NST+1];
    vec_t   vec_c [NST+1];

    assign vld_c[0] = v0_reg;
    assign vox_c[0] = vox0_reg;
    assign vec_c[0] = vec0_reg;

    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        rssc_cell #(.STAGE(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (vld_c[g]),
            .vox_in  (vox_c[g]),
            .vec_in  (vec_c[g]),
            .vld_out (vld_c[g+1]),
            .vox_out (vox_c[g+1]),
            .vec_out (vec_c[g+1])
        );
    end

    rssc_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (vld_c[NST]),
        .vox_in   (vox_c[NST]),
        .z_in     (vec_c[NST].z),
        .zero_in  (vec_c[NST].zero),
        .mode     (mode_reg),
        .beta     (beta_reg),
        .upper    (upper_reg),
        .lower    (lower_reg),
        .vld_out  (done),
        .nr_out   (new_real),
        .ni_out   (new_imag),
        .sel_out  (was_replaced),
        .last_out (last_out)
    );

endmodule
`default_nettype wire

/* rtl/rssc_checker.sv */
`default_nettype none
module rssc_checker
    import rssc_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic                     cfg_ready,
    input wire logic signed [DATA_W-1:0] new_real,
    input wire logic signed [DATA_W-1:0] new_imag,
    input wire logic                     was_replaced
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg not ready");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({start, done}))
        else $error("control unknown");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({new_real, new_imag, was_replaced}))
        else $error("result unknown");

    a_no_done_reset: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("done after reset");

endmodule

bind real_space_support_constraint_unit rssc_checker u_rssc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_ready    (cfg_ready),
    .new_real     (new_real),
    .new_imag     (new_imag),
    .was_replaced (was_replaced)
);
`default_nettype wire

/* test/real_space_support_constraint_unit_tb.sv */
`default_nettype none
module real_space_support_constraint_unit_tb;
    import rssc_pkg::*;

    localparam int STAGES = DEF_CORDIC_STAGES;
    localparam int DRAIN_CYCLES = STAGES + 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam longint ONE_Q16 = 64'sd65536;
    localparam longint PI_ANG = 64'sd843314857;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic signed [DATA_W-1:0] pr;
        logic signed [DATA_W-1:0] pi;
        logic                     sup;
        logic                     last;
    } voxel_in_t;

    typedef struct {
        logic signed [DATA_W-1:0] nr;
        logic signed [DATA_W-1:0] ni;
        logic                     repl;
        logic                     last;
    } voxel_out_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DATA_W-1:0] cur_real, cur_imag, prev_real, prev_imag;
    logic in_support, last_voxel;
    logic done;
    logic signed [DATA_W-1:0] new_real, new_imag;
    logic was_replaced, last_out;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    real_space_support_constraint_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cur_real(cur_real), .cur_imag(cur_imag),
        .prev_real(prev_real), .prev_imag(prev_imag),
        .in_support(in_support), .last_voxel(last_voxel),
        .done(done), .new_real(new_real), .new_imag(new_imag),
        .was_replaced(was_replaced), .last_out(last_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [MODE_W-1:0] cur_mode;
    longint cur_beta, cur_upper, cur_lower;

    voxel_in_t pending_voxels[$];
    voxel_out_t expected_voxels[$];
    voxel_in_t driven_voxel;
    int burst_left, gap_left;
    int mismatches;
    int cycles;
    longint atan_tab[24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422,
        8385879, 4193963, 2097109, 1048571, 524287, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint q16_round(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    function automatic longint voxel_phase(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_ANG : -PI_ANG;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
        end
        return (z + 64'sd16384) >>> 15;
    endfunction

    function automatic voxel_out_t support_update(voxel_in_t v);
        voxel_out_t o;
        longint cr, ci, pr, pi, b, ph;
        logic sel;
        cr = 64'(v.cr);
        ci = 64'(v.ci);
        pr = 64'(v.pr);
        pi = 64'(v.pi);
        b = cur_beta;
        sel = 1'b0;
        case (cur_mode)
            MODE_ER, MODE_HIO: sel = !v.sup;
            MODE_HIOP: sel = !v.sup || (cr < 0 && ci < 0);
            MODE_HPR: sel = !v.sup ||
                (((2 * cr - pr) * ONE_Q16 < (ONE_Q16 - b) * cr) &&
                 ((2 * ci - pi) * ONE_Q16 < (ONE_Q16 - b) * ci));
            MODE_RAAR: sel = !v.sup || ((2 * cr - pr) < 0 && (2 * ci - pi) < 0);
            MODE_PHIO:
            begin
                ph = voxel_phase(cr, ci);
                sel = !v.sup || ph > cur_upper || ph < cur_lower;
            end
            default: sel = 1'b0;
        endcase
        o.nr = v.cr;
        o.ni = v.ci;
        if (sel)
        begin
            if (cur_mode == MODE_ER)
            begin
                o.nr = '0;
                o.ni = '0;
            end
            else if (cur_mode == MODE_RAAR)
            begin
                o.nr = 32'(clamp32(q16_round(b * pr - (ONE_Q16 - 2 * b) * cr)));
                o.ni = 32'(clamp32(q16_round(b * pi - (ONE_Q16 - 2 * b) * ci)));
            end
            else
            begin
                o.nr = 32'(clamp32(pr - q16_round(b * cr)));
                o.ni = 32'(clamp32(pi - q16_round(b * ci)));
            end
        end
        o.repl = sel;
        o.last = v.last;
        return o;
    endfunction

    // sender: bursts and gaps, prediction at transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cur_real <= '0;
            cur_imag <= '0;
            prev_real <= '0;
            prev_imag <= '0;
            in_support <= 1'b0;
            last_voxel <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_voxels.push_back(support_update(driven_voxel));
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_voxels.size() > 0)
            begin
                driven_voxel = pending_voxels.pop_front();
                cur_real <= driven_voxel.cr;
                cur_imag <= driven_voxel.ci;
                prev_real <= driven_voxel.pr;
                prev_imag <= driven_voxel.pi;
                in_support <= driven_voxel.sup;
                last_voxel <= driven_voxel.last;
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        voxel_out_t e;
        if (rst_n && done)
        begin
            if (expected_voxels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d", new_real, new_imag);
            end
            else
            begin
                e = expected_voxels.pop_front();
                if (new_real !== e.nr || new_imag !== e.ni ||
                    was_replaced !== e.repl || last_out !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected %0d %0d %b %b got %0d %0d %b %b",
                                 e.nr, e.ni, e.repl, e.last,
                                 new_real, new_imag, was_replaced, last_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("real_space_support_constraint_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_MODE: cur_mode = val[MODE_W-1:0];
            REG_BETA: cur_beta = 64'(val[BETA_W-1:0]);
            REG_UPPER: cur_upper = 64'($signed(val[PHASE_W-1:0]));
            default: cur_lower = 64'($signed(val[PHASE_W-1:0]));
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_voxels.size() > 0 || start || expected_voxels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 2) - 1;
            3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            5: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_voxel(logic signed [DATA_W-1:0] cr, logic signed [DATA_W-1:0] ci,
                             logic signed [DATA_W-1:0] pr, logic signed [DATA_W-1:0] pi,
                             logic sup, logic last);
        voxel_in_t v;
        v.cr = cr;
        v.ci = ci;
        v.pr = pr;
        v.pi = pi;
        v.sup = sup;
        v.last = last;
        pending_voxels.push_back(v);
    endtask

    task automatic run_volume(int count);
        add_voxel(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0);
        add_voxel(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0);
        add_voxel(32'sh80000000, 32'sh7fffffff, 0, 0, 1'b1, 1'b0);
        add_voxel(0, 0, 32'sh10000, -32'sh10000, 1'b1, 1'b0);
        add_voxel(-32'sh10000, 0, 0, 0, 1'b1, 1'b0);
        add_voxel(-32'sh10000, -32'sh1, 0, 0, 1'b1, 1'b0);
        for (int i = 0; i < count; i++)
            add_voxel(pick_value(), pick_value(), pick_value(), pick_value(),
                      $urandom_range(0, 2) != 0, i == count - 1);
        wait_idle();
    endtask

    initial
    begin
        logic [MODE_W-1:0] modes[8] = '{MODE_ER, MODE_HIO, MODE_HIOP, MODE_HPR,
                                        MODE_RAAR, MODE_PHIO, MODE_SPARE_A, MODE_SPARE_B};
        mismatches = 0;
        cycles = 0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        cur_mode = MODE_ER;
        cur_beta = 64'(BETA_RST);
        cur_upper = 64'(UPPER_RST);
        cur_lower = 64'(LOWER_RST);
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        run_volume(40);
        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_MODE, {29'($urandom), modes[m]});
            write_reg(REG_BETA, (m % 3 == 0) ? 32'd0 : (m % 3 == 1) ? 32'd131072 : 32'h3ffff);
            write_reg(REG_UPPER, (m % 2) ? 32'd0 : 32'd25736);
            write_reg(REG_LOWER, (m % 2) ? 32'hffff9b78 : 32'd0);
            run_volume(50);
            write_reg(REG_BETA, $urandom);
            write_reg(REG_UPPER, $urandom);
            write_reg(REG_LOWER, $urandom);
            run_volume(60);
        end
        write_reg(REG_MODE, 32'(MODE_PHIO));
        write_reg(REG_UPPER, 32'hffff9b78);
        write_reg(REG_LOWER, 32'd25736);
        run_volume(40);
        if (mismatches == 0)
            $display("real_space_support_constraint_unit: match");
        else
            $display("real_space_support_constraint_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/rssc_pkg.sv
rtl/rssc_cell.sv
rtl/rssc_update.sv
rtl/real_space_support_constraint_unit.sv
rtl/rssc_checker.sv
test/real_space_support_constraint_unit_tb.sv
